### design/srsw_pkg.sv
// ----------------------------------------------------------------------------
// srsw_pkg
// Shared types and constants of the selective-repeat send window core.
// ----------------------------------------------------------------------------
package srsw_pkg;

  localparam int          WINDOW_SLOTS_DEF = 16;
  localparam int          SEQ_W            = 32;
  localparam int          LEN_W            = 16;
  localparam logic [4:0]  SLOTS_RST        = 5'd16;
  localparam logic [31:0] START_SEQ_RST    = 32'd0;

  localparam logic [0:0]  REG_SLOTS_IN_USE = 1'b0;
  localparam logic [0:0]  REG_START_SEQ    = 1'b1;

  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_SEND = 2'd1,
    CMD_RETX = 2'd2,
    CMD_ACK  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    RK_LOADED   = 3'd0,
    RK_FULL     = 3'd1,
    RK_TX       = 3'd2,
    RK_DONE     = 3'd3,
    RK_ACK_HIT  = 3'd4,
    RK_ACK_MISS = 3'd5
  } kind_t;

  typedef struct packed {
    cmd_t              command;
    logic [LEN_W-1:0]  seg_len;
    logic [SEQ_W-1:0]  ack_num;
  } in_word_t;

  typedef struct packed {
    kind_t             result_kind;
    logic [3:0]        slot_index;
    logic [SEQ_W-1:0]  seq_out;
    logic [LEN_W-1:0]  len_out;
    logic [4:0]        count;
    logic              last;
  } out_word_t;

  typedef struct packed {
    logic [SEQ_W-1:0]  seq;
    logic [LEN_W-1:0]  len;
  } slot_meta_t;

endpackage

### design/selective_repeat_send_window_core.sv
// ----------------------------------------------------------------------------
// selective_repeat_send_window_core
// Slot metadata engine of a selective-repeat sender window over a ring.
//
//   Channel  Direction  Handshake               Word
//   in_      input      in_valid / in_stall     in_word_t
//   out_     output     out_valid / out_stall   out_word_t
//   APB      config     psel/penable/pwrite     slots_in_use @0, start_seq @4
//
// A load passes through the load and finish states before its result sits in
// the output register. Send, retransmit and ack walk head to tail one slot per
// cycle through the metadata RAM read port, send and retransmit only while the
// output is not stalled; a walk covers at most ring size slots. An ack that
// confirms the head slot then slides the window, freeing each confirmed slot.
// A new word is taken only when the engine is idle and the output is empty.
// A stalled output freezes the send walk in place; reset is synchronous.
// ----------------------------------------------------------------------------
module selective_repeat_send_window_core
  import srsw_pkg::*;
#(
  parameter int WINDOW_SLOTS = WINDOW_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_word_t    in_word,
  output logic        out_valid,
  input  logic        out_stall,
  output out_word_t   out_word,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IW = $clog2(WINDOW_SLOTS);
  localparam int CW = $clog2(WINDOW_SLOTS + 1);

  typedef enum logic [1:0] {
    ST_EMPTY     = 2'd0,
    ST_UNSENT    = 2'd1,
    ST_SENT      = 2'd2,
    ST_CONFIRMED = 2'd3
  } slot_st_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_WALK,
    S_SLIDE,
    S_FIN
  } state_t;

  function automatic logic [CW-1:0] ring_of(input logic [4:0] v);
    if (v == 5'd0) begin
      return CW'(1);
    end
    if (int'(v) > WINDOW_SLOTS) begin
      return CW'(WINDOW_SLOTS);
    end
    return CW'(v);
  endfunction

  state_t            state_r;
  logic [4:0]        sin_r;
  logic [31:0]       start_r;
  slot_st_t          status_r [WINDOW_SLOTS];
  logic [IW-1:0]     head_r;
  logic [IW-1:0]     tail_r;
  logic [CW-1:0]     free_r;
  logic [SEQ_W-1:0]  next_seq_r;

  cmd_t              cmd_r;
  logic [LEN_W-1:0]  len_r;
  logic [SEQ_W-1:0]  ack_r;
  logic [IW-1:0]     cur_r;
  logic [CW-1:0]     steps_r;
  logic              iss_r;
  logic              p_valid_r;
  logic              p_go_r;
  logic              p_last_r;
  logic [IW-1:0]     p_cur_r;
  logic [CW-1:0]     sent_r;
  logic [CW-1:0]     freed_r;
  logic [IW-1:0]     m_slot_r;
  logic [SEQ_W-1:0]  m_seq_r;
  out_word_t         fin_r;
  out_word_t         out_r;
  logic              out_valid_r;

  logic [CW-1:0]     ring_w;
  logic [CW-1:0]     cur_inc;
  logic [IW-1:0]     cur_nxt;
  slot_st_t          st_cur;
  logic              adv;
  logic              ack_mode;
  logic              walk_go;
  logic              walk_end;
  logic              issue_go;
  logic              in_fire;
  logic              cfg_wr;
  logic              load_ok;
  logic              ram_we;
  logic [IW-1:0]     ram_raddr;
  slot_meta_t        ram_wdata;
  slot_meta_t        ram_rdata;
  logic              ack_hit;

  assign ring_w   = ring_of(sin_r);
  assign cur_inc  = CW'(cur_r) + CW'(1);
  assign cur_nxt  = (cur_inc >= ring_w) ? '0 : IW'(cur_inc);
  assign st_cur   = status_r[cur_r];
  assign adv      = !out_valid_r || !out_stall;
  assign ack_mode = (cmd_r == CMD_ACK);
  assign walk_go  = (state_r == S_WALK) && (ack_mode || adv);
  assign walk_end = (cur_nxt == tail_r) || ((steps_r + CW'(1)) == ring_w);
  assign issue_go = (cmd_r == CMD_RETX) ? (st_cur == ST_UNSENT || st_cur == ST_SENT)
                                        : (st_cur == ST_UNSENT);
  assign in_stall = (state_r != S_IDLE) || out_valid_r;
  assign in_fire  = in_valid && !in_stall;
  assign cfg_wr   = psel && penable && pwrite;
  assign load_ok  = (free_r != '0) && (st_cur == ST_EMPTY);
  assign ram_we   = (state_r == S_LOAD) && load_ok;
  assign ram_wdata = '{seq: next_seq_r, len: len_r};
  assign ram_raddr = walk_go ? cur_r : p_cur_r;
  assign ack_hit  = p_go_r && (ram_rdata.seq == ack_r);

  assign pready    = 1'b1;
  assign prdata    = (paddr[2] == REG_START_SEQ) ? start_r : {27'd0, sin_r};
  assign out_valid = out_valid_r;
  assign out_word  = out_r;

  srsw_ram #(
    .WIDTH($bits(slot_meta_t)),
    .DEPTH(WINDOW_SLOTS)
  ) u_meta_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(cur_r),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sin_r       <= SLOTS_RST;
      start_r     <= START_SEQ_RST;
      head_r      <= '0;
      tail_r      <= '0;
      free_r      <= ring_of(SLOTS_RST);
      next_seq_r  <= START_SEQ_RST;
      iss_r       <= 1'b0;
      p_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < WINDOW_SLOTS; i++) begin
        status_r[i] <= ST_EMPTY;
      end
    end else begin
      if (!out_stall) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            cmd_r     <= in_word.command;
            len_r     <= in_word.seg_len;
            ack_r     <= in_word.ack_num;
            cur_r     <= (in_word.command == CMD_LOAD) ? tail_r : head_r;
            steps_r   <= '0;
            sent_r    <= '0;
            iss_r     <= 1'b1;
            p_valid_r <= 1'b0;
            state_r   <= (in_word.command == CMD_LOAD) ? S_LOAD : S_WALK;
          end
        end

        S_LOAD: begin
          fin_r <= '{result_kind: RK_FULL, slot_index: '0, seq_out: '0,
                     len_out: '0, count: '0, last: 1'b1};
          if (load_ok) begin
            status_r[cur_r] <= ST_UNSENT;
            next_seq_r      <= next_seq_r + SEQ_W'(1);
            tail_r          <= cur_nxt;
            free_r          <= free_r - CW'(1);
            fin_r <= '{result_kind: RK_LOADED, slot_index: 4'(cur_r),
                       seq_out: next_seq_r, len_out: len_r, count: '0,
                       last: 1'b1};
          end
          state_r <= S_FIN;
        end

        S_WALK: begin
          if (walk_go) begin
            if (iss_r) begin
              p_valid_r <= 1'b1;
              p_cur_r   <= cur_r;
              p_last_r  <= walk_end;
              p_go_r    <= ack_mode ? (st_cur != ST_EMPTY) : issue_go;
              if (!ack_mode && issue_go) begin
                status_r[cur_r] <= ST_SENT;
              end
              cur_r   <= cur_nxt;
              steps_r <= steps_r + CW'(1);
              if (walk_end) begin
                iss_r <= 1'b0;
              end
            end else begin
              p_valid_r <= 1'b0;
            end

            if (p_valid_r) begin
              if (!ack_mode) begin
                if (p_go_r) begin
                  out_valid_r <= 1'b1;
                  out_r <= '{result_kind: RK_TX, slot_index: 4'(p_cur_r),
                             seq_out: ram_rdata.seq, len_out: ram_rdata.len,
                             count: '0, last: 1'b0};
                  sent_r <= sent_r + CW'(1);
                end
                if (p_last_r) begin
                  fin_r <= '{result_kind: RK_DONE, slot_index: '0, seq_out: '0,
                             len_out: '0, count: 5'(sent_r + CW'(p_go_r)),
                             last: 1'b1};
                  state_r <= S_FIN;
                end
              end else if (ack_hit) begin
                status_r[p_cur_r] <= ST_CONFIRMED;
                m_slot_r <= p_cur_r;
                m_seq_r  <= ram_rdata.seq;
                fin_r <= '{result_kind: RK_ACK_HIT, slot_index: 4'(p_cur_r),
                           seq_out: ram_rdata.seq, len_out: '0, count: '0,
                           last: 1'b1};
                if (p_cur_r == head_r) begin
                  cur_r   <= p_cur_r;
                  freed_r <= '0;
                  state_r <= S_SLIDE;
                end else begin
                  state_r <= S_FIN;
                end
              end else if (p_last_r) begin
                fin_r <= '{result_kind: RK_ACK_MISS, slot_index: '0, seq_out: '0,
                           len_out: '0, count: '0, last: 1'b1};
                state_r <= S_FIN;
              end
            end
          end
        end

        S_SLIDE: begin
          if (st_cur == ST_CONFIRMED && freed_r < ring_w) begin
            status_r[cur_r] <= ST_EMPTY;
            if (free_r < ring_w) begin
              free_r <= free_r + CW'(1);
            end
            freed_r <= freed_r + CW'(1);
            cur_r   <= cur_nxt;
            head_r  <= cur_nxt;
          end else begin
            fin_r <= '{result_kind: RK_ACK_HIT, slot_index: 4'(m_slot_r),
                       seq_out: m_seq_r, len_out: '0, count: 5'(freed_r),
                       last: 1'b1};
            state_r <= S_FIN;
          end
        end

        S_FIN: begin
          if (adv) begin
            out_valid_r <= 1'b1;
            out_r       <= fin_r;
            state_r     <= S_IDLE;
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase

      if (cfg_wr) begin
        head_r <= '0;
        tail_r <= '0;
        for (int i = 0; i < WINDOW_SLOTS; i++) begin
          status_r[i] <= ST_EMPTY;
        end
        if (paddr[2] == REG_SLOTS_IN_USE) begin
          sin_r      <= pwdata[4:0];
          free_r     <= ring_of(pwdata[4:0]);
          next_seq_r <= start_r;
        end else begin
          start_r    <= pwdata;
          free_r     <= ring_w;
          next_seq_r <= pwdata;
        end
      end
    end
  end

  a_free_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    free_r <= ring_w)
    else $error("free slot count exceeds the ring size");

  a_ptr_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
    (head_r < IW'(ring_w) || CW'(head_r) < ring_w) && CW'(tail_r) < ring_w)
    else $error("head or tail pointer outside the ring");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.last |-> state_r == S_IDLE)
    else $error("final word shown while the engine is still busy");

  a_walk_pending: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WALK && !iss_r |-> p_valid_r)
    else $error("walk ended its issue phase with no read pending");

endmodule

### design/srsw_ram.sv
// ----------------------------------------------------------------------------
// srsw_ram
// Simple dual-port RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module srsw_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
